// ===== hdl/dma_pkg.sv =====
// shared types, constants and codes of the decimated moving average
`default_nettype none

package dma_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int GROUP_W     = 8;
  localparam int WLEN_W      = 7;
  localparam int MINF_W      = 7;
  localparam int FILL_W      = 7;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;

  // default for the top level parameter
  localparam int WINDOW_DEPTH_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL      = 2'd2;

  // register reset values
  localparam logic [GROUP_W-1:0] GROUP_SIZE_RST    = 8'd1;
  localparam logic [WLEN_W-1:0]  WINDOW_LENGTH_RST = 7'd64;
  localparam logic [MINF_W-1:0]  MIN_FILL_RST      = 7'd1;

  // request operation codes
  localparam logic OP_READING = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [FILL_W-1:0]      fill_level;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GDIV,
    ST_READ,
    ST_UPDATE,
    ST_WDIV
  } dma_state_t;

endpackage

`default_nettype wire

// ===== hdl/decimated_moving_average.sv =====
// top level: group decimator feeding a ring-buffer moving average
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_item_t  (operation, sample)
//   out_     output     out_valid / out_ready   out_item_t (average, fill_level)
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// a clear or a reading that leaves its group open is handled in ST_IDLE alone;
// a reading that reaches the window goes through ST_READ and ST_UPDATE, then ST_WDIV
// once the fill reaches min_fill; one that closes a group first passes ST_GDIV for
// the group mean; one serial divider (DIV_W = 24 bits by default) serves both means
// synchronous active-low reset; ring entries at or above the written mark read as zero,
// so no clearing pass is needed; a full output register holds the next result back
`default_nettype none

module decimated_moving_average
  import dma_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int LEN_W  = (WLEN_W > CNT_W) ? WLEN_W : CNT_W;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int GS_W   = SAMPLE_BITS + GROUP_W;
  localparam int DIV_W  = (GS_W > SUM_W) ? GS_W : SUM_W;

  // configuration
  logic [GROUP_W-1:0] group_size_r;
  logic [WLEN_W-1:0]  window_length_r;
  logic [MINF_W-1:0]  min_fill_r;

  // running state
  dma_state_t         state_r, state_nxt;
  logic [GS_W-1:0]    gsum_r, gsum_nxt;
  logic [GROUP_W-1:0] gcnt_r, gcnt_nxt;
  logic [SUM_W-1:0]   wsum_r, wsum_nxt;
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [CNT_W-1:0]   hwm_r, hwm_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // ram and divider hookup
  logic                   ram_we;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [GROUP_W-1:0]     div_divisor;
  logic [DIV_W-1:0]       div_quo;
  div_stat_t              div_stat;

  // combinational helpers
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       slot_inc;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]       sum_upd;
  logic [FILL_W-1:0]      fill_upd;
  logic [GS_W-1:0]        gsum_add;
  logic [GROUP_W-1:0]     gcnt_inc;
  logic                   in_acc;
  logic                   out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r    <= GROUP_SIZE_RST;
      window_length_r <= WINDOW_LENGTH_RST;
      min_fill_r      <= MIN_FILL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUP_SIZE:    group_size_r    <= cfg_wdata[GROUP_W-1:0];
        REG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WLEN_W-1:0];
        REG_MIN_FILL:      min_fill_r      <= cfg_wdata[MINF_W-1:0];
        default: ;
      endcase
    end
  end

  // window length of zero acts as one, above the depth as the depth
  always_comb begin
    if (window_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(window_length_r) > LEN_W'(WINDOW_DEPTH)) begin
      eff_len = LEN_W'(WINDOW_DEPTH);
    end else begin
      eff_len = LEN_W'(window_length_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign gsum_add = gsum_r + GS_W'(in_data.sample);
  assign gcnt_inc = gcnt_r + GROUP_W'(1);

  // entries at or past the written mark read as zero, whatever the ram holds there
  assign old_val  = (LEN_W'(wptr_r) < LEN_W'(hwm_r)) ? ram_rdata : '0;
  assign sum_upd  = wsum_r - SUM_W'(old_val) + SUM_W'(val_r);
  assign slot_inc = LEN_W'(wptr_r) + LEN_W'(1);
  assign fill_upd = (LEN_W'(fill_r) < eff_len) ? fill_r + FILL_W'(1) : fill_r;
  assign out_load = (state_r == ST_WDIV) && div_stat.done && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    gsum_nxt      = gsum_r;
    gcnt_nxt      = gcnt_r;
    wsum_nxt      = wsum_r;
    wptr_nxt      = wptr_r;
    hwm_nxt       = hwm_r;
    fill_nxt      = fill_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    div_dividend  = DIV_W'(sum_upd);
    div_divisor   = GROUP_W'(fill_upd);

    case (state_r)
      ST_IDLE: begin
        div_dividend = DIV_W'(gsum_add);
        div_divisor  = gcnt_inc;
        if (in_acc) begin
          if (in_data.operation == OP_CLEAR) begin
            gsum_nxt = '0;
            gcnt_nxt = '0;
            wsum_nxt = '0;
            wptr_nxt = '0;
            hwm_nxt  = '0;
            fill_nxt = '0;
          end else if (group_size_r > GROUP_W'(1)) begin
            if (gcnt_inc < group_size_r || gcnt_inc == '0) begin
              gsum_nxt = gsum_add;
              gcnt_nxt = gcnt_inc;
            end else begin
              // group full: mean over the actual count
              gsum_nxt  = '0;
              gcnt_nxt  = '0;
              div_start = 1'b1;
              state_nxt = ST_GDIV;
            end
          end else begin
            val_nxt   = in_data.sample;
            state_nxt = ST_READ;
          end
        end
      end
      ST_GDIV: begin
        if (div_stat.done) begin
          val_nxt   = div_quo[SAMPLE_BITS-1:0];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we   = 1'b1;
        wsum_nxt = sum_upd;
        wptr_nxt = (slot_inc >= eff_len) ? '0 : PTR_W'(slot_inc);
        if (LEN_W'(wptr_r) == LEN_W'(hwm_r)) begin
          hwm_nxt = hwm_r + CNT_W'(1);
        end
        fill_nxt = fill_upd;
        if (fill_upd < FILL_W'(min_fill_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (out_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.average    = div_quo[SAMPLE_BITS-1:0];
          out_data_nxt.fill_level = fill_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gsum_r      <= '0;
      gcnt_r      <= '0;
      wsum_r      <= '0;
      wptr_r      <= '0;
      hwm_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gsum_r      <= gsum_nxt;
      gcnt_r      <= gcnt_nxt;
      wsum_r      <= wsum_nxt;
      wptr_r      <= wptr_nxt;
      hwm_r       <= hwm_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (wptr_r),
    .rdata (ram_rdata)
  );

  dma_div #(
    .DVD_W (DIV_W),
    .DVS_W (GROUP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // the divider is never running while a new request can come in
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while accepting a request");

  // the write pointer never runs past the written mark of the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(wptr_r) <= LEN_W'(hwm_r))
    else $error("write pointer beyond written entries");

  // a closed group restarts before its mean is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GDIV) |-> (gcnt_r == '0 && gsum_r == '0))
    else $error("group state not restarted");

  // a loaded result always counts at least one entry
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && out_data.fill_level != '0))
    else $error("result loaded with empty window");

endmodule

`default_nettype wire

// ===== hdl/dma_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module dma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/dma_div.sv =====
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module dma_div
  import dma_pkg::*;
#(
  parameter int DVD_W = 24,
  parameter int DVS_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ===== tb/tb_decimated_moving_average.sv =====
// testbench for the decimated moving average: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module tb_decimated_moving_average
  import dma_pkg::*;
();

  localparam int WINDOW_DEPTH    = WINDOW_DEPTH_DEF;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASE_COUNT     = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int DIR_ROWS        = 31;
  localparam int FIXED_PHASES    = 8;

  // index with no register behind it, writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      wdata;
    in_item_t              req;
    out_item_t             res;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] group_size;
    logic [CFG_W-1:0] window_length;
    logic [CFG_W-1:0] min_fill;
  } setting_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // typed expectation travels with the request it belongs to
  logic                 req_typed = 1'b0;
  out_item_t            req_res = '0;

  bit                   hold_req = 1'b0;
  bit                   quiet = 1'b0;
  int                   mismatch_count = 0;
  int                   idle_cycles = 0;
  out_item_t            avg_expect_q [$];

  // mirror of the block's running state and registers
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW_DEPTH];
  int unsigned            win_sum;
  int unsigned            wr_ptr;
  int unsigned            fill_cnt;
  int unsigned            grp_sum;
  logic [GROUP_W-1:0]     grp_cnt;
  logic [GROUP_W-1:0]     grp_size;
  logic [WLEN_W-1:0]      win_len;
  logic [MINF_W-1:0]      min_fill;

  dir_row_t dir_plan [DIR_ROWS] = '{
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'h0000}, '{16'h0000, 7'd1}},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'hFFFF}, '{16'h7FFF, 7'd2}},
    '{ROW_REQ,   '0, '0, '{OP_CLEAR,   16'hFFFF}, '0},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'hFFFF}, '{16'hFFFF, 7'd1}},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h5555}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'hAAAA}, '0},
    '{ROW_CFG,   REG_GROUP_SIZE, 8'd3, '0, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h0100}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h0200}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h0301}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'hFFFF}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'hFFFF}, '0},
    // group size drops to the count already held
    '{ROW_CFG,   REG_GROUP_SIZE, 8'd2, '0, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h0000}, '0},
    '{ROW_CFG,   REG_GROUP_SIZE, 8'd0, '0, '0},
    '{ROW_CFG,   REG_WINDOW_LENGTH, 8'd2, '0, '0},
    '{ROW_CFG,   REG_MIN_FILL, 8'd0, '0, '0},
    // pointer and fill sit above the shortened window
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h1234}, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h4321}, '0},
    '{ROW_REQ,   '0, '0, '{OP_CLEAR,   16'h0000}, '0},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'h8000}, '{16'h8000, 7'd1}},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'h0000}, '{16'h4000, 7'd2}},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'h0000}, '{16'h0000, 7'd2}},
    // length zero acts as one, min fill above it blocks every result
    '{ROW_CFG,   REG_WINDOW_LENGTH, 8'h80, '0, '0},
    '{ROW_CFG,   REG_MIN_FILL, 8'hFF, '0, '0},
    '{ROW_CFG,   REG_SPARE, 8'h5A, '0, '0},
    '{ROW_REQ,   '0, '0, '{OP_READING, 16'h7FFF}, '0},
    '{ROW_CFG,   REG_MIN_FILL, 8'd1, '0, '0},
    '{ROW_CFG,   REG_WINDOW_LENGTH, 8'd100, '0, '0},
    '{ROW_REQ,   '0, '0, '{OP_CLEAR,   16'h0000}, '0},
    '{ROW_TYPED, '0, '0, '{OP_READING, 16'hFFFF}, '{16'hFFFF, 7'd1}}
  };

  setting_t phase_plan [FIXED_PHASES] = '{
    '{8'd1,   8'd64,  8'd1},
    '{8'd255, 8'd64,  8'd1},
    '{8'd1,   8'd64,  8'd64},
    '{8'd2,   8'd1,   8'd1},
    '{8'd0,   8'd0,   8'd0},
    '{8'd4,   8'd16,  8'd8},
    '{8'd1,   8'd127, 8'd1},
    '{8'd3,   8'd5,   8'd6}
  };

  decimated_moving_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) ring_q[i] = '0;
    win_sum  = 0;
    wr_ptr   = 0;
    fill_cnt = 0;
    grp_sum  = 0;
    grp_cnt  = '0;
  endtask

  task automatic load_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_GROUP_SIZE:    grp_size = val;
      REG_WINDOW_LENGTH: win_len = val[WLEN_W-1:0];
      REG_MIN_FILL:      min_fill = val[MINF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic advance_window(input in_item_t req, output bit has_res,
                                output out_item_t res);
    int unsigned value;
    int unsigned eff_len;
    int unsigned slot;
    has_res = 1'b0;
    res = '0;
    if (req.operation == OP_CLEAR) begin
      clear_window();
      return;
    end
    value = req.sample;
    if (grp_size > 1) begin
      grp_sum += value;
      grp_cnt = grp_cnt + 8'd1;
      if (grp_cnt < grp_size || grp_cnt == 0) return;
      value = grp_sum / grp_cnt;
      grp_sum = 0;
      grp_cnt = '0;
    end
    if (win_len == 0) eff_len = 1;
    else if (win_len > WINDOW_DEPTH) eff_len = WINDOW_DEPTH;
    else eff_len = win_len;
    slot = wr_ptr % WINDOW_DEPTH;
    win_sum = win_sum - ring_q[slot] + value;
    ring_q[slot] = value[SAMPLE_BITS-1:0];
    wr_ptr = slot + 1;
    if (wr_ptr >= eff_len) wr_ptr = 0;
    if (fill_cnt < eff_len) fill_cnt++;
    if (fill_cnt < min_fill || fill_cnt == 0) return;
    has_res = 1'b1;
    res.average = SAMPLE_BITS'(win_sum / fill_cnt);
    res.fill_level = FILL_W'(fill_cnt);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // scoreboard: predicts at request acceptance, checks at result acceptance
  always @(posedge clk) begin
    bit        has_res;
    out_item_t pred;
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) load_setting(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        advance_window(in_data, has_res, pred);
        if (req_typed) avg_expect_q.push_back(req_res);
        else if (has_res) avg_expect_q.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (avg_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending, average", out_data.average, 0);
        end else begin
          want = avg_expect_q.pop_front();
          if (out_data.average !== want.average)
            report_mismatch("average", out_data.average, want.average);
          if (out_data.fill_level !== want.fill_level)
            report_mismatch("fill_level", out_data.fill_level, want.fill_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic offer(input in_item_t req, input bit typed, input out_item_t res);
    in_valid  <= 1'b1;
    in_data   <= req;
    req_typed <= typed;
    req_res   <= res;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // wait for every result plus the slowest request that gives none
  task automatic drain();
    in_valid <= 1'b0;
    // let the scoreboard queue the last request's result before the queue is checked
    @(posedge clk);
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t rand_request();
    in_item_t r;
    r.operation = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_READING;
    case ($urandom_range(0, 9))
      0:       r.sample = '0;
      1:       r.sample = '1;
      default: r.sample = SAMPLE_BITS'($urandom);
    endcase
    return r;
  endfunction

  initial begin : stimulus
    bit       last_cfg;
    setting_t cur;
    clear_window();
    grp_size = GROUP_SIZE_RST;
    win_len  = WINDOW_LENGTH_RST;
    min_fill = MIN_FILL_RST;
    last_cfg = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_plan[i].kind == ROW_CFG) begin
        if (!last_cfg) drain();
        write_reg(dir_plan[i].idx, dir_plan[i].wdata);
        last_cfg = 1'b1;
      end else begin
        offer(dir_plan[i].req, dir_plan[i].kind == ROW_TYPED, dir_plan[i].res);
        last_cfg = 1'b0;
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      if (p < FIXED_PHASES) begin
        cur = phase_plan[p];
      end else begin
        cur.group_size    = CFG_W'($urandom_range(1, 6));
        cur.window_length = CFG_W'($urandom_range(1, WINDOW_DEPTH));
        cur.min_fill      = CFG_W'($urandom_range(0, cur.window_length));
      end
      write_reg(REG_GROUP_SIZE, cur.group_size);
      write_reg(REG_WINDOW_LENGTH, cur.window_length);
      write_reg(REG_MIN_FILL, cur.min_fill);
      // back up the block by holding results off while requests keep coming
      if (p == 0) hold_req = 1'b1;
      if (p == PHASE_COUNT - 1) quiet = 1'b1;
      repeat (ITEMS_PER_PHASE) offer(rand_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
